// ===== sv/lzwc_pkg.sv =====
package lzwc_pkg;

   localparam int DICT_SIZE  = 4095;
   localparam int CODE_BITS  = 12;
   localparam int BYTE_BITS  = 8;
   localparam int FIRST_CODE = 256;
   localparam int CodeCap    = (1 << CODE_BITS) - 1;
   // Codes above this limit are never assigned, so a code always fits in CODE_BITS.
   localparam int CODE_LIMIT = (DICT_SIZE < CodeCap) ? DICT_SIZE : CodeCap;

   // The hash store is indexed by a slot number as wide as a code.
   localparam int SLOT_BITS  = 12;
   localparam int SLOT_DEPTH = 1 << SLOT_BITS;
   localparam int EPOCH_BITS = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CODE_BITS-1:0]  code_type;
   typedef logic [BYTE_BITS-1:0]  data_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [EPOCH_BITS-1:0] epoch_type;

   // One slot of the hash store. A slot is in use only when its epoch matches
   // the current stream and its code is nonzero.
   typedef struct packed {
      epoch_type epoch;
      code_type  code;
      code_type  prefix;
      data_type  data;
   } entry_type;

   typedef struct packed {
      data_type data;
      logic     last;
      logic     first;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic     clearing;
      code_type next_free;
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_EMIT,
      ST_EMIT_LAST
   } state_type;

   function automatic slot_type slot_hash(code_type prefix, data_type data);
      slot_type h;
      h = slot_type'(prefix) ^ slot_type'({data, 4'h0}) ^ slot_type'(data);
      return h;
   endfunction

endpackage

// ===== sv/lzwc_ram.sv =====
module lzwc_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lzwc_front.sv =====
module lzwc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  lzwc_pkg::data_type       req_data_byte,
   input  logic                     req_end_of_input,
   output logic                     req_stall,
   input  logic                     pop,
   output lzwc_pkg::queue_out_type  q
);

   lzwc_pkg::item_type                  slots_ff [lzwc_pkg::QUEUE_DEPTH];
   logic [lzwc_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lzwc_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lzwc_pkg::QCOUNT_BITS-1:0]    count_ff, count_in;
   logic                                first_ff, first_in;
   logic                                full;
   logic                                accept;
   lzwc_pkg::item_type                  new_item;

   assign full   = (count_ff == lzwc_pkg::QCOUNT_BITS'(lzwc_pkg::QUEUE_DEPTH));
   assign accept = req_valid && !full;

   assign req_stall = full;

   // The front knows on its own whether a beat opens a stream: the beat after
   // an end marker, or the first one after reset.
   always_comb begin
      new_item.data  = req_data_byte;
      new_item.last  = req_end_of_input;
      new_item.first = first_ff;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      first_in  = first_ff;
      if (accept) begin
         wr_ptr_in = lzwc_pkg::QPTR_BITS'(wr_ptr_ff + 1'b1);
         first_in  = req_end_of_input;
      end
      if (pop) begin
         rd_ptr_in = lzwc_pkg::QPTR_BITS'(rd_ptr_ff + 1'b1);
      end
      case ({accept, pop})
         2'b10:   count_in = lzwc_pkg::QCOUNT_BITS'(count_ff + 1'b1);
         2'b01:   count_in = lzwc_pkg::QCOUNT_BITS'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         first_ff  <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slots_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_comb begin
      q.valid = (count_ff != '0);
      q.item  = slots_ff[rd_ptr_ff];
   end

endmodule

// ===== sv/lzwc_back.sv =====
module lzwc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  lzwc_pkg::queue_out_type  q,
   output logic                     pop,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output lzwc_pkg::code_type       rsp_code,
   output logic                     rsp_last_code,
   output lzwc_pkg::status_type     status
);

   lzwc_pkg::state_type  state_ff, state_in;
   lzwc_pkg::code_type   prefix_ff, prefix_in;
   lzwc_pkg::code_type   next_free_ff, next_free_in;
   lzwc_pkg::epoch_type  epoch_ff, epoch_in;
   lzwc_pkg::slot_type   clear_addr_ff, clear_addr_in;
   lzwc_pkg::slot_type   slot_ff, slot_in;
   lzwc_pkg::data_type   data_ff, data_in;
   logic                 last_ff, last_in;
   lzwc_pkg::code_type   emit_code_ff, emit_code_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lzwc_pkg::code_type   rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rd_en;
   lzwc_pkg::slot_type   rd_addr;
   logic                 wr_en;
   lzwc_pkg::slot_type   wr_addr;
   lzwc_pkg::entry_type  wr_data;
   lzwc_pkg::entry_type  rd_data;
   logic                 out_free;
   logic                 slot_live;
   logic                 slot_match;
   lzwc_pkg::slot_type   slot_next;

   lzwc_ram #(
      .WIDTH ($bits(lzwc_pkg::entry_type)),
      .DEPTH (lzwc_pkg::SLOT_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign slot_live  = (rd_data.epoch == epoch_ff) && (rd_data.code != '0);
   assign slot_match = slot_live && (rd_data.prefix == prefix_ff) && (rd_data.data == data_ff);
   assign slot_next  = lzwc_pkg::slot_type'(slot_ff + 1'b1);

   always_comb begin
      state_in      = state_ff;
      prefix_in     = prefix_ff;
      next_free_in  = next_free_ff;
      epoch_in      = epoch_ff;
      clear_addr_in = clear_addr_ff;
      slot_in       = slot_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      emit_code_in  = emit_code_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_code_in   = rsp_code_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = slot_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = '0;

      case (state_ff)
         lzwc_pkg::ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            clear_addr_in = lzwc_pkg::slot_type'(clear_addr_ff + 1'b1);
            if (clear_addr_ff == '1) begin
               state_in = lzwc_pkg::ST_IDLE;
            end
         end

         lzwc_pkg::ST_IDLE: begin
            if (q.valid) begin
               pop     = 1'b1;
               data_in = q.item.data;
               last_in = q.item.last;
               if (q.item.first) begin
                  prefix_in = lzwc_pkg::code_type'(q.item.data);
                  state_in  = q.item.last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
               end else begin
                  slot_in  = lzwc_pkg::slot_hash(prefix_ff, q.item.data);
                  rd_en    = 1'b1;
                  rd_addr  = slot_in;
                  state_in = lzwc_pkg::ST_CHECK;
               end
            end
         end

         lzwc_pkg::ST_CHECK: begin
            if (slot_match) begin
               prefix_in = rd_data.code;
               state_in  = last_ff ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
            end else if (slot_live) begin
               // Another pair sits here; probe the following slot.
               slot_in = slot_next;
               rd_en   = 1'b1;
               rd_addr = slot_next;
            end else begin
               // An empty slot ends the probe: the pair is new and goes here while codes remain.
               emit_code_in = prefix_ff;
               prefix_in    = lzwc_pkg::code_type'(data_ff);
               if (next_free_ff < lzwc_pkg::code_type'(lzwc_pkg::CODE_LIMIT)) begin
                  wr_en          = 1'b1;
                  wr_data.epoch  = epoch_ff;
                  wr_data.code   = next_free_ff;
                  wr_data.prefix = prefix_ff;
                  wr_data.data   = data_ff;
                  next_free_in   = lzwc_pkg::code_type'(next_free_ff + 1'b1);
               end
               state_in = lzwc_pkg::ST_EMIT;
            end
         end

         lzwc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = emit_code_ff;
               rsp_last_in  = 1'b0;
               state_in     = last_ff ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
            end
         end

         lzwc_pkg::ST_EMIT_LAST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = prefix_ff;
               rsp_last_in   = 1'b1;
               prefix_in     = '0;
               next_free_in  = lzwc_pkg::code_type'(lzwc_pkg::FIRST_CODE);
               epoch_in      = lzwc_pkg::epoch_type'(epoch_ff + 1'b1);
               clear_addr_in = '0;
               // Slots of old streams become stale by epoch; once the epoch
               // wraps they must be wiped before any can look current again.
               state_in = (epoch_ff == '1) ? lzwc_pkg::ST_CLEAR : lzwc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lzwc_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lzwc_pkg::ST_CLEAR;
         clear_addr_ff <= '0;
         epoch_ff      <= '0;
         next_free_ff  <= lzwc_pkg::code_type'(lzwc_pkg::FIRST_CODE);
         prefix_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         epoch_ff      <= epoch_in;
         next_free_ff  <= next_free_in;
         prefix_ff     <= prefix_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      data_ff      <= data_in;
      last_ff      <= last_in;
      emit_code_ff <= emit_code_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_last_code = rsp_last_ff;

   always_comb begin
      status.clearing  = (state_ff == lzwc_pkg::ST_CLEAR);
      status.next_free = next_free_ff;
   end

endmodule

// ===== sv/lzw_compressor_12bit_core.sv =====
// LZW compressor with 12-bit codes, unpacked output.
// Request channel (req_valid / req_stall): one byte per beat, req_end_of_input
// set on the final byte of a stream. Response channel (rsp_valid / rsp_stall):
// one code per beat, rsp_last_code set on the final code of a stream.
// A byte gives no code on a dictionary hit, one code on a miss, and one more
// code at the end of a stream. A two-beat queue sits between request intake
// and the compression engine, and a registered response stage follows it.
// Steps: a byte that opens a stream only becomes the prefix; any other byte is
// hashed and its slot probed (one probe per cycle on the store read port) until
// a match or an empty slot; a miss then gives out a code, and the end of a
// stream gives out the final code.
// After reset the hash store is wiped, one slot per cycle, with no
// bytes consumed; the same wipe follows every 16th stream. Beats offered in
// that time wait in the queue.
// When the receiver stalls, the held code stays put; the engine waits only
// when it has a new code to give, and the queue keeps taking up to two beats.
module lzw_compressor_12bit_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  lzwc_pkg::data_type  req_data_byte,
   input  logic                req_end_of_input,
   output logic                req_stall,
   output logic                rsp_valid,
   output lzwc_pkg::code_type  rsp_code,
   output logic                rsp_last_code,
   input  logic                rsp_stall
);

   lzwc_pkg::queue_out_type  q;
   logic                     pop;
   lzwc_pkg::status_type     status;

   lzwc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .req_stall        (req_stall),
      .pop              (pop),
      .q                (q)
   );

   lzwc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q             (q),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_code      (rsp_code),
      .rsp_last_code (rsp_last_code),
      .status        (status)
   );

`ifndef SYNTHESIS
   a_next_free_range: assert property (@(posedge clock) disable iff (reset)
      status.next_free >= lzwc_pkg::code_type'(lzwc_pkg::FIRST_CODE) &&
      status.next_free <= lzwc_pkg::code_type'(lzwc_pkg::CODE_LIMIT))
      else $error("next free code out of range");

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !pop)
      else $error("queue popped during store wipe");

   a_pop_only_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q.valid)
      else $error("queue popped while empty");
`endif

endmodule
